>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers. Each expects clk and rst_n in scope.

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/mlet_pkg.sv
package mlet_pkg;

  localparam int ENTRIES    = 32;
  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_IP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_PORT = CFG_IDX_W'(1);

  localparam logic [MAC_W-1:0] MAC_BCAST    = {MAC_W{1'b1}};
  localparam logic [15:0]      MCAST_PREFIX = 16'h3333;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_LEARNED = 3'd2,
    ST_UPDATED = 3'd3,
    ST_BCAST   = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   from_ip;
    logic [PORT_W-1:0] from_port;
  } req_t;

  typedef struct packed {
    logic [IP_W-1:0]   bcast_ip;
    logic [PORT_W-1:0] bcast_port;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
  } res_t;

endpackage

>>> design/mac_learning_endpoint_table_core.sv
// MAC learning endpoint table.
//
// Input channel (in_valid / in_stall): one frame header per word. in_cmd = 1
// learns in_src_mac with endpoint in_from_ip / in_from_port; in_cmd = 0 looks
// up in_dst_mac and returns the stored endpoint, or the broadcast endpoint on
// a miss.
// Result channel (out_valid / out_stall): one word per input word, in order,
// with a status code and the endpoint (zero for learn words).
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
// the broadcast IPv4 address, index 1 the broadcast UDP port; other indexes
// are dropped. cfg_ready is always high. Write only while the block is idle.
// A word passes the input stage, then the result register driving out_valid.
// Throughput: one word per cycle while out_stall is low. The 32-entry register
// CAM compares all entries against the key and commits a learn or update in the
// same cycle, so a word always sees the table left by the word before it.
// Reset clears the table, the broadcast endpoint and both pipeline stages.
// When out_stall holds the result register, the input stage holds its word
// and raises in_stall; nothing is lost or repeated.
module mac_learning_endpoint_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [mlet_pkg::MAC_W-1:0]      in_dst_mac,
  input  logic [mlet_pkg::MAC_W-1:0]      in_src_mac,
  input  logic [mlet_pkg::IP_W-1:0]       in_from_ip,
  input  logic [mlet_pkg::PORT_W-1:0]     in_from_port,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mlet_pkg::STATUS_W-1:0]   out_status,
  output logic [mlet_pkg::IP_W-1:0]       out_dest_ip,
  output logic [mlet_pkg::PORT_W-1:0]     out_dest_port,
  // configuration port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlet_pkg::*;

  cfg_t cfg;
  req_t in_req;
  res_t res;

  // input stage
  logic s_valid_r;
  logic s_valid_nxt;
  req_t s_req_r;

  // result register
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;

  logic out_free;
  logic s_fire;
  logic in_accept;

  assign in_req = '{cmd:       in_cmd,
                    dst_mac:   in_dst_mac,
                    src_mac:   in_src_mac,
                    from_ip:   in_from_ip,
                    from_port: in_from_port};

  // result register can load when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign s_fire    = s_valid_r && out_free;
  assign in_stall  = s_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  mlet_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // table commits its write only when the word advances to the result register
  mlet_cam u_cam (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s_fire),
    .req   (s_req_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    if (in_accept) begin
      s_valid_nxt = 1'b1;
    end else if (s_fire) begin
      s_valid_nxt = 1'b0;
    end else begin
      s_valid_nxt = s_valid_r;
    end
  end

  always_comb begin
    if (s_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_req_r <= in_req;
    end
    if (s_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_dest_ip   = out_res_r.dest_ip;
  assign out_dest_port = out_res_r.dest_port;

endmodule

>>> design/mlet_cfg_regs.sv
module mlet_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlet_pkg::CFG_DATA_W-1:0] cfg_data,
  output mlet_pkg::cfg_t                  cfg
);
  import mlet_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BCAST_IP:   cfg_nxt.bcast_ip   = cfg_data[IP_W-1:0];
        CFG_BCAST_PORT: cfg_nxt.bcast_port = cfg_data[PORT_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/mlet_cam.sv
`include "assert_macros.svh"

module mlet_cam (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  mlet_pkg::req_t req,
  input  mlet_pkg::cfg_t cfg,
  output mlet_pkg::res_t res
);
  import mlet_pkg::*;

  logic [ENTRIES-1:0] valid_r;
  logic [MAC_W-1:0]   mac_r  [ENTRIES];
  logic [IP_W-1:0]    ip_r   [ENTRIES];
  logic [PORT_W-1:0]  port_r [ENTRIES];

  logic [MAC_W-1:0]   key;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] first_free;
  logic [ENTRIES-1:0] wr_vec;
  logic               hit;
  logic               any_free;
  logic               group_mac;
  logic               upd;
  logic               learn;
  logic [IP_W-1:0]    hit_ip;
  logic [PORT_W-1:0]  hit_port;

  assign key = req.cmd ? req.src_mac : req.dst_mac;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (mac_r[i] == key);
    end
  end

  assign hit        = |hit_vec;
  assign free_vec   = ~valid_r;
  assign any_free   = |free_vec;
  // isolate the lowest free slot
  assign first_free = free_vec & (~free_vec + 1'b1);
  assign group_mac  = (req.src_mac == MAC_BCAST) ||
                      (req.src_mac[MAC_W-1 -: 16] == MCAST_PREFIX);

  assign upd    = req.cmd && hit;
  assign learn  = req.cmd && !hit && !group_mac && any_free;
  assign wr_vec = upd ? hit_vec : (learn ? first_free : '0);

  // hit vector is at most one-hot, so an and-or mux selects the endpoint
  always_comb begin
    hit_ip   = '0;
    hit_port = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_ip   = hit_ip   | (ip_r[i]   & {IP_W{hit_vec[i]}});
      hit_port = hit_port | (port_r[i] & {PORT_W{hit_vec[i]}});
    end
  end

  always_comb begin
    res.dest_ip   = '0;
    res.dest_port = '0;
    if (!req.cmd) begin
      if (hit) begin
        res.status    = ST_HIT;
        res.dest_ip   = hit_ip;
        res.dest_port = hit_port;
      end else begin
        res.status    = ST_MISS;
        res.dest_ip   = cfg.bcast_ip;
        res.dest_port = cfg.bcast_port;
      end
    end else if (hit) begin
      res.status = ST_UPDATED;
    end else if (group_mac) begin
      res.status = ST_BCAST;
    end else if (any_free) begin
      res.status = ST_LEARNED;
    end else begin
      res.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (fire && learn) begin
      valid_r <= valid_r | first_free;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire && wr_vec[i]) begin
        mac_r[i]  <= req.src_mac;
        ip_r[i]   <= req.from_ip;
        port_r[i] <= req.from_port;
      end
    end
  end

  `ASSERT_ALWAYS(a_hit_unique, $onehot0(hit_vec))
  `ASSERT_NEXT(a_learn_grows, fire && learn,
               $countones(valid_r) == $past($countones(valid_r)) + 1)
  `ASSERT_IMPL(a_full_only_when_full, fire && (res.status == ST_FULL), &valid_r)
  `ASSERT_NEXT(a_no_learn_keeps, fire && !learn, valid_r == $past(valid_r))

endmodule

>>> bench/mac_learning_endpoint_table_checker.sv
`timescale 1ns / 1ps

module mac_learning_endpoint_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [mlet_pkg::MAC_W-1:0]      in_dst_mac,
  input  logic [mlet_pkg::MAC_W-1:0]      in_src_mac,
  input  logic [mlet_pkg::IP_W-1:0]       in_from_ip,
  input  logic [mlet_pkg::PORT_W-1:0]     in_from_port,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [mlet_pkg::STATUS_W-1:0]   out_status,
  input  logic [mlet_pkg::IP_W-1:0]       out_dest_ip,
  input  logic [mlet_pkg::PORT_W-1:0]     out_dest_port,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mlet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlet_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              replies_owed
);

  import mlet_pkg::*;

  localparam int PRINT_CAP = 40;

  logic              slot_used [ENTRIES];
  logic [MAC_W-1:0]  slot_mac  [ENTRIES];
  logic [IP_W-1:0]   slot_ip   [ENTRIES];
  logic [PORT_W-1:0] slot_port [ENTRIES];
  logic [IP_W-1:0]   flood_ip;
  logic [PORT_W-1:0] flood_port;
  res_t              endpoint_replies [$];
  int                fault_tally = 0;
  int                owed_count  = 0;

  assign mismatches   = fault_tally;
  assign replies_owed = owed_count;

  function automatic int find_slot(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Resolve one frame header against the shadow table; learn words update it.
  function automatic res_t resolve_frame(input req_t frame);
    res_t reply;
    int   hit;
    int   free_slot;
    reply.dest_ip   = '0;
    reply.dest_port = '0;
    if (!frame.cmd) begin
      hit = find_slot(frame.dst_mac);
      if (hit >= 0) begin
        reply.status    = ST_HIT;
        reply.dest_ip   = slot_ip[hit];
        reply.dest_port = slot_port[hit];
      end else begin
        reply.status    = ST_MISS;
        reply.dest_ip   = flood_ip;
        reply.dest_port = flood_port;
      end
    end else begin
      hit = find_slot(frame.src_mac);
      if (hit >= 0) begin
        slot_ip[hit]   = frame.from_ip;
        slot_port[hit] = frame.from_port;
        reply.status   = ST_UPDATED;
      end else if (frame.src_mac == MAC_BCAST ||
                   frame.src_mac[MAC_W-1 -: 16] == MCAST_PREFIX) begin
        reply.status = ST_BCAST;
      end else begin
        free_slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!slot_used[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          reply.status = ST_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_mac[free_slot]  = frame.src_mac;
          slot_ip[free_slot]   = frame.from_ip;
          slot_port[free_slot] = frame.from_port;
          reply.status         = ST_LEARNED;
        end
      end
    end
    return reply;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fault_tally++;
    if (fault_tally <= PRINT_CAP)
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    req_t frame;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      flood_ip   = '0;
      flood_port = '0;
      endpoint_replies.delete();
    end else begin
      // results first: a word leaving now was accepted at an earlier edge
      if (out_valid && !out_stall) begin
        if (endpoint_replies.size() == 0) begin
          report_mismatch("word with no frame pending", '0, 32'(out_status));
        end else begin
          want = endpoint_replies.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_status));
          if (out_dest_ip !== want.dest_ip)
            report_mismatch("dest_ip", want.dest_ip, out_dest_ip);
          if (out_dest_port !== want.dest_port)
            report_mismatch("dest_port", 32'(want.dest_port), 32'(out_dest_port));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BCAST_IP:   flood_ip = cfg_data;
          CFG_BCAST_PORT: flood_port = cfg_data[PORT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        frame.cmd       = in_cmd;
        frame.dst_mac   = in_dst_mac;
        frame.src_mac   = in_src_mac;
        frame.from_ip   = in_from_ip;
        frame.from_port = in_from_port;
        endpoint_replies.push_back(resolve_frame(frame));
      end
    end
    owed_count <= endpoint_replies.size();
  end

endmodule

>>> bench/mac_learning_endpoint_table_core_tb.sv
`timescale 1ns / 1ps

module mac_learning_endpoint_table_core_tb;

  import mlet_pkg::*;

  localparam int POOL_SIZE       = 48;
  localparam int ITEMS_PER_PHASE = 420;
  localparam int LONG_HOLD       = 80;
  localparam int CYCLE_LIMIT     = 200000;

  // Indexes the block must drop: the top one exercises every index bit.
  localparam logic [CFG_IDX_W-1:0] CFG_STRAY_TOP = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_STRAY_LOW = CFG_IDX_W'(2);

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  in_cmd       = 1'b0;
  logic [MAC_W-1:0]      in_dst_mac   = '0;
  logic [MAC_W-1:0]      in_src_mac   = '0;
  logic [IP_W-1:0]       in_from_ip   = '0;
  logic [PORT_W-1:0]     in_from_port = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IP_W-1:0]       out_dest_ip;
  logic [PORT_W-1:0]     out_dest_port;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int mismatches;
  int replies_owed;
  int cycle_count = 0;

  // long_hold_req is shared between the sender and the result sink.
  bit long_hold_req = 1'b0;
  bit send_steady   = 1'b0;
  bit sink_steady   = 1'b0;

  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  mac_learning_endpoint_table_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_dst_mac    (in_dst_mac),
    .in_src_mac    (in_src_mac),
    .in_from_ip    (in_from_ip),
    .in_from_port  (in_from_port),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_dest_ip   (out_dest_ip),
    .out_dest_port (out_dest_port),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mac_learning_endpoint_table_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_dst_mac    (in_dst_mac),
    .in_src_mac    (in_src_mac),
    .in_from_ip    (in_from_ip),
    .in_from_port  (in_from_port),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_dest_ip   (out_dest_ip),
    .out_dest_port (out_dest_port),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .replies_owed  (replies_owed)
  );

  // Abort a hung run; the limit covers every word waiting out the longest
  // sender gap, the longest sink stall and both long holds, many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL mac_learning_endpoint_table_core");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[MAC_W-1:0];
  endfunction

  // Offer one frame header and hold it until the block takes it. Valid stays
  // high on return so a back-to-back word goes out without valid dropping.
  task automatic send_frame(input logic cmd, input logic [MAC_W-1:0] dst,
                            input logic [MAC_W-1:0] src, input logic [IP_W-1:0] ip,
                            input logic [PORT_W-1:0] port);
    int gap;
    // flip between idling and back-to-back stretches now and then
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_dst_mac   <= dst;
    in_src_mac   <= src;
    in_from_ip   <= ip;
    in_from_port <= port;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every word in flight has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
    repeat (2) @(posedge clk);
  endtask

  // Program the broadcast endpoint, preceded by a write to an index the block
  // must drop. Hold valid across the three words and lower it once at the end.
  task automatic set_flood(input logic [CFG_DATA_W-1:0] ip_word,
                           input logic [CFG_DATA_W-1:0] port_word,
                           input logic [CFG_IDX_W-1:0] stray_idx);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      case (k)
        0: begin
          cfg_index <= stray_idx;
          cfg_data  <= $urandom;
        end
        1: begin
          cfg_index <= CFG_BCAST_IP;
          cfg_data  <= ip_word;
        end
        default: begin
          cfg_index <= CFG_BCAST_PORT;
          cfg_data  <= port_word;
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: keys come mostly from a small pool so learns, updates
  // and hits repeat, with a share of fresh addresses to push the table full.
  task automatic run_traffic(input int count, input bit with_hold);
    logic              cmd;
    logic [MAC_W-1:0]  key;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 3) long_hold_req = 1'b1;
      cmd = ($urandom_range(0, 1) == 1);
      if ($urandom_range(0, 6) == 0)
        key = random_mac();
      else
        key = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 7))
        0:       ip = '0;
        1:       ip = '1;
        default: ip = IP_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       port = '0;
        1:       port = '1;
        default: port = PORT_W'($urandom);
      endcase
      // the field the command ignores still gets random content
      if (cmd)
        send_frame(cmd, random_mac(), key, ip, port);
      else
        send_frame(cmd, key, random_mac(), ip, port);
    end
  endtask

  // Result sink: stall a random spell before each word, none in steady stretches,
  // and on request hold off for a long run so the block backs up into
  // in_stall while the sender keeps offering words.
  initial begin : result_sink
    int hold;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
        hold = sink_steady ? 0 : $urandom_range(0, 5);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    // Pool: broadcast, two multicast keys, near misses of both, all-zero MAC.
    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = random_mac();
    mac_pool[0]                 = MAC_BCAST;
    mac_pool[1][MAC_W-1 -: 16]  = MCAST_PREFIX;
    mac_pool[2][MAC_W-1 -: 16]  = MCAST_PREFIX;
    mac_pool[3][MAC_W-1 -: 16]  = MCAST_PREFIX ^ 16'h0100;
    mac_pool[4]                 = MAC_BCAST ^ MAC_W'(1);
    mac_pool[5]                 = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words against the reset broadcast endpoint (all zero).
    // Lookups on an empty table miss, including the broadcast address.
    send_frame(1'b0, '0, random_mac(), '1, '1);
    send_frame(1'b0, MAC_BCAST, '0, '0, '0);
    // Broadcast and multicast sources are skipped, whatever the low bytes.
    send_frame(1'b1, '0, MAC_BCAST, '1, '1);
    send_frame(1'b1, MAC_BCAST, {MCAST_PREFIX, 32'h0}, '1, '1);
    send_frame(1'b1, '0, {MCAST_PREFIX, 32'hFFFF_FFFF}, '0, '0);
    // Learn the all-zero MAC with an all-ones endpoint, hit it, overwrite it.
    send_frame(1'b1, '1, '0, '1, '1);
    send_frame(1'b0, '0, '1, '0, '0);
    send_frame(1'b1, random_mac(), '0, '0, '0);
    send_frame(1'b0, '0, random_mac(), '1, '1);
    send_frame(1'b1, '0, '0, 32'h1234_5678, 16'hFEDC);
    send_frame(1'b0, '0, '0, '0, '0);
    // Near misses of the group tests are ordinary unicast keys.
    send_frame(1'b1, '0, {16'h3332, 32'hFFFF_FFFF}, 32'hA5A5_A5A5, 16'h5A5A);
    send_frame(1'b1, MAC_BCAST, MAC_BCAST ^ MAC_W'(1), 32'h5A5A_5A5A, 16'hA5A5);
    send_frame(1'b1, '1, MAC_W'(1), '1, '0);
    send_frame(1'b0, {MCAST_PREFIX, 32'h0}, '0, '0, '0);
    send_frame(1'b0, MAC_BCAST ^ MAC_W'(1), MAC_BCAST, '1, '1);
    send_frame(1'b0, {16'h3332, 32'hFFFF_FFFF}, '1, '0, '0);
    send_frame(1'b0, MAC_W'(1), '0, '0, '1);
    send_frame(1'b1, '0, MAC_W'(1), '0, '1);
    send_frame(1'b0, MAC_W'(1), '0, '0, '0);
    drain();

    // All-ones endpoint; junk in the upper data bits of the port word.
    set_flood('1, 32'hA5A5_FFFF, CFG_STRAY_TOP);
    run_traffic(ITEMS_PER_PHASE, 1'b1);
    drain();

    set_flood('0, 32'hFFFF_0000, CFG_STRAY_LOW);
    run_traffic(ITEMS_PER_PHASE, 1'b0);
    drain();

    set_flood($urandom, $urandom, CFG_IDX_W'($urandom_range(2, 14)));
    run_traffic(ITEMS_PER_PHASE, 1'b1);
    drain();

    set_flood($urandom, $urandom, CFG_IDX_W'($urandom_range(2, 14)));
    run_traffic(ITEMS_PER_PHASE, 1'b0);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("PASS mac_learning_endpoint_table_core");
    end else begin
      $display("FAIL mac_learning_endpoint_table_core");
    end
    $finish;
  end

endmodule
